[src/c6502_pkg.sv]
// ----------------------------------------------------------------------------
// c6502_pkg: shared types and constants of the 6502 execute core
// Opcode numbers, flag bit positions, reset values and the word types.
// ----------------------------------------------------------------------------
package c6502_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);

  // Opcode numbers
  localparam logic [5:0] OP_LDA = 6'd0,  OP_LDX = 6'd1,  OP_LDY = 6'd2;
  localparam logic [5:0] OP_STA = 6'd3,  OP_STX = 6'd4,  OP_STY = 6'd5;
  localparam logic [5:0] OP_TAX = 6'd6,  OP_TAY = 6'd7,  OP_TSX = 6'd8;
  localparam logic [5:0] OP_TXA = 6'd9,  OP_TXS = 6'd10, OP_TYA = 6'd11;
  localparam logic [5:0] OP_INC = 6'd12, OP_INX = 6'd13, OP_INY = 6'd14;
  localparam logic [5:0] OP_DEC = 6'd15, OP_DEX = 6'd16, OP_DEY = 6'd17;
  localparam logic [5:0] OP_ASLM = 6'd18, OP_LSRM = 6'd19;
  localparam logic [5:0] OP_ROLM = 6'd20, OP_RORM = 6'd21;
  localparam logic [5:0] OP_ASLA = 6'd22, OP_LSRA = 6'd23;
  localparam logic [5:0] OP_ROLA = 6'd24, OP_RORA = 6'd25;
  localparam logic [5:0] OP_AND = 6'd26, OP_EOR = 6'd27, OP_ORA = 6'd28;
  localparam logic [5:0] OP_BIT = 6'd29, OP_ADC = 6'd30, OP_SBC = 6'd31;
  localparam logic [5:0] OP_CMP = 6'd32, OP_CPX = 6'd33, OP_CPY = 6'd34;
  localparam logic [5:0] OP_CLC = 6'd35, OP_CLD = 6'd36, OP_CLI = 6'd37;
  localparam logic [5:0] OP_CLV = 6'd38, OP_SEC = 6'd39, OP_SED = 6'd40;
  localparam logic [5:0] OP_SEI = 6'd41;
  localparam logic [5:0] OP_BCC = 6'd42, OP_BCS = 6'd43, OP_BEQ = 6'd44;
  localparam logic [5:0] OP_BMI = 6'd45, OP_BNE = 6'd46, OP_BPL = 6'd47;
  localparam logic [5:0] OP_BVC = 6'd48, OP_BVS = 6'd49;
  localparam logic [5:0] OP_JMP = 6'd50, OP_JSR = 6'd51, OP_RTS = 6'd52;
  localparam logic [5:0] OP_RTI = 6'd53, OP_BRK = 6'd54;
  localparam logic [5:0] OP_PHA = 6'd55, OP_PHP = 6'd56;
  localparam logic [5:0] OP_PLA = 6'd57, OP_PLP = 6'd58;

  // Flag bit positions in P
  localparam int FL_C = 0, FL_Z = 1, FL_I = 2, FL_D = 3, FL_B = 4;
  localparam int FL_V = 6, FL_N = 7;

  localparam logic [7:0]  SP_RESET = 8'hFF;
  localparam logic [7:0]  P_RESET  = 8'h04;
  localparam logic [15:0] PC_RESET = 16'hFFFC;
  localparam logic [7:0]  STACK_PAGE = 8'h01;

  typedef struct packed {
    logic [5:0] opcode;
    logic [7:0] operand_byte;
    logic [7:0] addr_low;
    logic [7:0] addr_high;
  } in_word_t;

  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  sp_out;
    logic [7:0]  status_out;
    logic [15:0] pc_out;
    logic        last;
  } out_word_t;

  // Stack store access from the sequencer
  typedef struct packed {
    logic                re;
    logic [STACK_AW-1:0] raddr;
    logic                we;
    logic [STACK_AW-1:0] waddr;
    logic [7:0]          wdata;
  } stk_req_t;

endpackage

[src/c6502_if.sv]
// ----------------------------------------------------------------------------
// c6502_if: valid/ready word channel
// Carries one word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface c6502_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/cpu6502_execute_core.sv]
// Throughput: one word per cycle on the output while out_ready is high; a
// plain op each cycle while the output is free, a multi-step op holds off
// the input until its last word is loaded.
// Reset (rst_n, synchronous): registers take their reset values, then the
// stack RAM is cleared before the first word is taken.
// ----------------------------------------------------------------------------
// cpu6502_execute_core: 6502 execute core, binary arithmetic only
// Register sequencer around a page-one stack RAM.
// ----------------------------------------------------------------------------
module cpu6502_execute_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  in_opcode,
  input  logic [7:0]  in_operand_byte,
  input  logic [7:0]  in_addr_low,
  input  logic [7:0]  in_addr_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_write_valid,
  output logic [15:0] out_write_address,
  output logic [7:0]  out_write_data,
  output logic [7:0]  out_acc_out,
  output logic [7:0]  out_x_out,
  output logic [7:0]  out_y_out,
  output logic [7:0]  out_sp_out,
  output logic [7:0]  out_status_out,
  output logic [15:0] out_pc_out,
  output logic        out_last
);

  c6502_if #(.word_t(c6502_pkg::in_word_t))  in_ch ();
  c6502_if #(.word_t(c6502_pkg::out_word_t)) out_ch ();

  logic [15:0]          irq_vector_r;
  c6502_pkg::stk_req_t  stk_req;
  logic [7:0]           stk_rdata;
  logic                 ram_busy;

  // Break vector register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irq_vector_r <= 16'h0000;
    end else if (cfg_we) begin
      irq_vector_r <= cfg_wdata;
    end
  end

  assign in_ch.valid = in_valid;
  assign in_ready    = in_ch.ready;
  assign in_ch.data  = '{opcode: in_opcode, operand_byte: in_operand_byte,
                         addr_low: in_addr_low, addr_high: in_addr_high};

  assign out_valid         = out_ch.valid;
  assign out_ch.ready      = out_ready;
  assign out_write_valid   = out_ch.data.write_valid;
  assign out_write_address = out_ch.data.write_address;
  assign out_write_data    = out_ch.data.write_data;
  assign out_acc_out       = out_ch.data.acc_out;
  assign out_x_out         = out_ch.data.x_out;
  assign out_y_out         = out_ch.data.y_out;
  assign out_sp_out        = out_ch.data.sp_out;
  assign out_status_out    = out_ch.data.status_out;
  assign out_pc_out        = out_ch.data.pc_out;
  assign out_last          = out_ch.data.last;

  c6502_exec u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .irq_vector (irq_vector_r),
    .ram_busy   (ram_busy),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .stk_req    (stk_req),
    .stk_rdata  (stk_rdata)
  );

  c6502_stack_ram u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (stk_req),
    .rdata (stk_rdata),
    .busy  (ram_busy)
  );

endmodule

[src/c6502_stack_ram.sv]
// ----------------------------------------------------------------------------
// c6502_stack_ram: page-one stack store
// One write and one read port, registered read data, clearing pass after
// reset (one entry a cycle).
// ----------------------------------------------------------------------------
module c6502_stack_ram (
  input  logic                      clk,
  input  logic                      rst_n,
  input  c6502_pkg::stk_req_t       req,
  output logic [7:0]                rdata,
  output logic                      busy
);

  logic [7:0] mem [c6502_pkg::STACK_DEPTH];
  logic [c6502_pkg::STACK_AW:0] clr_r;
  logic [c6502_pkg::STACK_AW:0] clr_nxt;

  assign busy = ~clr_r[c6502_pkg::STACK_AW];

  // Clearing counter
  always_comb begin
    clr_nxt = busy ? clr_r + 1'b1 : clr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else begin
      clr_r <= clr_nxt;
    end
  end

  // Memory array
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_r[c6502_pkg::STACK_AW-1:0]] <= 8'h00;
    end else if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

[src/c6502_exec.sv]
// ----------------------------------------------------------------------------
// c6502_exec: register file and operation sequencer
// Single-step ops load their word when taken; pulls read the stack store one
// byte a cycle, pushes write one byte a cycle unless stalled, each as a word.
// ----------------------------------------------------------------------------
module c6502_exec (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [15:0]                 irq_vector,
  input  logic                        ram_busy,
  c6502_if.sink                       in_ch,
  c6502_if.source                     out_ch,
  output c6502_pkg::stk_req_t         stk_req,
  input  logic [7:0]                  stk_rdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PULL = 4'b0010,
    ST_PUSH = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  logic [7:0]  a_r, a_nxt, x_r, x_nxt, y_r, y_nxt, s_r, s_nxt, p_r, p_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [5:0]  op_r, op_nxt;
  logic [1:0]  cnt_r, cnt_nxt;      // pull/push step
  logic [7:0]  tmp_r, tmp_nxt;      // first pulled byte
  logic [7:0]  tmp2_r, tmp2_nxt;    // second pulled byte (RTI)
  logic [15:0] psh_pc_r, psh_pc_nxt;
  logic [7:0]  psh_p_r, psh_p_nxt;
  logic [15:0] new_pc_r, new_pc_nxt;
  logic        rd_pend_r, rd_pend_nxt;
  logic [7:0]  rd_byte;

  // output register
  logic                   ov_r, ov_nxt;
  c6502_pkg::out_word_t   od_r, od_nxt;

  logic        out_free;
  logic [5:0]  op;
  logic [7:0]  m, res8;
  logic [15:0] ea;
  logic [8:0]  sum;
  logic [7:0]  addend;
  logic        take;

  assign out_free   = ~ov_r | out_ch.ready;
  assign out_ch.valid = ov_r;
  assign out_ch.data  = od_r;
  assign in_ch.ready  = (state_r == ST_IDLE) & out_free & ~ram_busy;

  assign op = in_ch.data.opcode;
  assign m  = in_ch.data.operand_byte;
  assign ea = {in_ch.data.addr_high, in_ch.data.addr_low};

  // forward a write in flight to the same stack entry
  logic                            fw_v_r;
  logic [c6502_pkg::STACK_AW-1:0]  fw_a_r;
  logic [7:0]                      fw_d_r;
  logic [c6502_pkg::STACK_AW-1:0]  rd_a_r;
  assign rd_byte = (fw_v_r && fw_a_r == rd_a_r) ? fw_d_r : stk_rdata;

  always_comb begin
    state_nxt = state_r;
    a_nxt = a_r; x_nxt = x_r; y_nxt = y_r; s_nxt = s_r; p_nxt = p_r;
    pc_nxt = pc_r; op_nxt = op_r; cnt_nxt = cnt_r;
    tmp_nxt = tmp_r; tmp2_nxt = tmp2_r;
    psh_pc_nxt = psh_pc_r; psh_p_nxt = psh_p_r; new_pc_nxt = new_pc_r;
    rd_pend_nxt = 1'b0;
    ov_nxt = ov_r & ~out_ch.ready;
    od_nxt = od_r;
    stk_req = '0;
    res8 = 8'h00;
    addend = m;
    sum = '0;
    take = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          op_nxt = op;
          od_nxt = '0;
          od_nxt.last = 1'b1;
          case (op)
            c6502_pkg::OP_LDA: a_nxt = m;
            c6502_pkg::OP_LDX: x_nxt = m;
            c6502_pkg::OP_LDY: y_nxt = m;
            c6502_pkg::OP_TAX: x_nxt = a_r;
            c6502_pkg::OP_TAY: y_nxt = a_r;
            c6502_pkg::OP_TSX: x_nxt = s_r;
            c6502_pkg::OP_TXA: a_nxt = x_r;
            c6502_pkg::OP_TXS: s_nxt = x_r;
            c6502_pkg::OP_TYA: a_nxt = y_r;
            c6502_pkg::OP_INX: x_nxt = x_r + 8'd1;
            c6502_pkg::OP_INY: y_nxt = y_r + 8'd1;
            c6502_pkg::OP_DEX: x_nxt = x_r - 8'd1;
            c6502_pkg::OP_DEY: y_nxt = y_r - 8'd1;
            c6502_pkg::OP_AND: a_nxt = a_r & m;
            c6502_pkg::OP_EOR: a_nxt = a_r ^ m;
            c6502_pkg::OP_ORA: a_nxt = a_r | m;
            default: ;
          endcase
          // N/Z after register loads, transfers, logic ops and index inc/dec
          case (op)
            c6502_pkg::OP_LDA, c6502_pkg::OP_TXA, c6502_pkg::OP_TYA,
            c6502_pkg::OP_AND, c6502_pkg::OP_EOR, c6502_pkg::OP_ORA: begin
              p_nxt[c6502_pkg::FL_Z] = (a_nxt == 8'h00);
              p_nxt[c6502_pkg::FL_N] = a_nxt[7];
            end
            c6502_pkg::OP_LDX, c6502_pkg::OP_TAX, c6502_pkg::OP_TSX,
            c6502_pkg::OP_INX, c6502_pkg::OP_DEX: begin
              p_nxt[c6502_pkg::FL_Z] = (x_nxt == 8'h00);
              p_nxt[c6502_pkg::FL_N] = x_nxt[7];
            end
            c6502_pkg::OP_LDY, c6502_pkg::OP_TAY, c6502_pkg::OP_INY,
            c6502_pkg::OP_DEY: begin
              p_nxt[c6502_pkg::FL_Z] = (y_nxt == 8'h00);
              p_nxt[c6502_pkg::FL_N] = y_nxt[7];
            end
            default: ;
          endcase
          // stores, memory read-modify-write and accumulator shifts
          case (op)
            c6502_pkg::OP_STA, c6502_pkg::OP_STX, c6502_pkg::OP_STY,
            c6502_pkg::OP_INC, c6502_pkg::OP_DEC,
            c6502_pkg::OP_ASLM, c6502_pkg::OP_LSRM,
            c6502_pkg::OP_ROLM, c6502_pkg::OP_RORM,
            c6502_pkg::OP_ASLA, c6502_pkg::OP_LSRA,
            c6502_pkg::OP_ROLA, c6502_pkg::OP_RORA: begin
              case (op)
                c6502_pkg::OP_STA: res8 = a_r;
                c6502_pkg::OP_STX: res8 = x_r;
                c6502_pkg::OP_STY: res8 = y_r;
                c6502_pkg::OP_INC: res8 = m + 8'd1;
                c6502_pkg::OP_DEC: res8 = m - 8'd1;
                c6502_pkg::OP_ASLM: res8 = {m[6:0], 1'b0};
                c6502_pkg::OP_LSRM: res8 = {1'b0, m[7:1]};
                c6502_pkg::OP_ROLM: res8 = {m[6:0], p_r[c6502_pkg::FL_C]};
                c6502_pkg::OP_RORM: res8 = {p_r[c6502_pkg::FL_C], m[7:1]};
                c6502_pkg::OP_ASLA: res8 = {a_r[6:0], 1'b0};
                c6502_pkg::OP_LSRA: res8 = {1'b0, a_r[7:1]};
                c6502_pkg::OP_ROLA: res8 = {a_r[6:0], p_r[c6502_pkg::FL_C]};
                c6502_pkg::OP_RORA: res8 = {p_r[c6502_pkg::FL_C], a_r[7:1]};
                default: res8 = 8'h00;
              endcase
              case (op)
                c6502_pkg::OP_ASLM, c6502_pkg::OP_ROLM:
                  p_nxt[c6502_pkg::FL_C] = m[7];
                c6502_pkg::OP_LSRM, c6502_pkg::OP_RORM:
                  p_nxt[c6502_pkg::FL_C] = m[0];
                c6502_pkg::OP_ASLA, c6502_pkg::OP_ROLA:
                  p_nxt[c6502_pkg::FL_C] = a_r[7];
                c6502_pkg::OP_LSRA, c6502_pkg::OP_RORA:
                  p_nxt[c6502_pkg::FL_C] = a_r[0];
                default: ;
              endcase
              if (op != c6502_pkg::OP_STA && op != c6502_pkg::OP_STX &&
                  op != c6502_pkg::OP_STY) begin
                p_nxt[c6502_pkg::FL_Z] = (res8 == 8'h00);
                p_nxt[c6502_pkg::FL_N] = res8[7];
              end
              if (op == c6502_pkg::OP_ASLA || op == c6502_pkg::OP_LSRA ||
                  op == c6502_pkg::OP_ROLA || op == c6502_pkg::OP_RORA) begin
                a_nxt = res8;
              end else begin
                od_nxt.write_valid   = 1'b1;
                od_nxt.write_address = ea;
                od_nxt.write_data    = res8;
                if (in_ch.data.addr_high == c6502_pkg::STACK_PAGE) begin
                  stk_req.we    = 1'b1;
                  stk_req.waddr = in_ch.data.addr_low;
                  stk_req.wdata = res8;
                end
              end
            end
            default: ;
          endcase
          // arithmetic and flags
          case (op)
            c6502_pkg::OP_BIT: begin
              p_nxt[c6502_pkg::FL_Z] = ((a_r & m) == 8'h00);
              p_nxt[c6502_pkg::FL_N] = m[7];
              p_nxt[c6502_pkg::FL_V] = m[6];
            end
            c6502_pkg::OP_ADC, c6502_pkg::OP_SBC: begin
              addend = (op == c6502_pkg::OP_SBC) ? ~m : m;
              sum = {1'b0, addend} + {1'b0, a_r} + {8'h00, p_r[c6502_pkg::FL_C]};
              p_nxt[c6502_pkg::FL_V] = (a_r[7] ^ sum[7]) & (addend[7] ^ sum[7]);
              p_nxt[c6502_pkg::FL_C] = sum[8];
              a_nxt = sum[7:0];
              p_nxt[c6502_pkg::FL_Z] = (sum[7:0] == 8'h00);
              p_nxt[c6502_pkg::FL_N] = sum[7];
            end
            c6502_pkg::OP_CMP, c6502_pkg::OP_CPX, c6502_pkg::OP_CPY: begin
              res8 = (op == c6502_pkg::OP_CMP) ? a_r :
                     (op == c6502_pkg::OP_CPX) ? x_r : y_r;
              sum = {1'b0, res8} - {1'b0, m};
              p_nxt[c6502_pkg::FL_C] = ~sum[8];
              p_nxt[c6502_pkg::FL_Z] = (sum[7:0] == 8'h00);
              p_nxt[c6502_pkg::FL_N] = sum[7];
            end
            c6502_pkg::OP_CLC: p_nxt[c6502_pkg::FL_C] = 1'b0;
            c6502_pkg::OP_CLD: p_nxt[c6502_pkg::FL_D] = 1'b0;
            c6502_pkg::OP_CLI: p_nxt[c6502_pkg::FL_I] = 1'b0;
            c6502_pkg::OP_CLV: p_nxt[c6502_pkg::FL_V] = 1'b0;
            c6502_pkg::OP_SEC: p_nxt[c6502_pkg::FL_C] = 1'b1;
            c6502_pkg::OP_SED: p_nxt[c6502_pkg::FL_D] = 1'b1;
            c6502_pkg::OP_SEI: p_nxt[c6502_pkg::FL_I] = 1'b1;
            default: ;
          endcase
          // branches and jumps
          case (op)
            c6502_pkg::OP_BCC: take = ~p_r[c6502_pkg::FL_C];
            c6502_pkg::OP_BCS: take =  p_r[c6502_pkg::FL_C];
            c6502_pkg::OP_BEQ: take =  p_r[c6502_pkg::FL_Z];
            c6502_pkg::OP_BMI: take =  p_r[c6502_pkg::FL_N];
            c6502_pkg::OP_BNE: take = ~p_r[c6502_pkg::FL_Z];
            c6502_pkg::OP_BPL: take = ~p_r[c6502_pkg::FL_N];
            c6502_pkg::OP_BVC: take = ~p_r[c6502_pkg::FL_V];
            c6502_pkg::OP_BVS: take =  p_r[c6502_pkg::FL_V];
            default: take = 1'b0;
          endcase
          if (take) pc_nxt = pc_r + {{8{m[7]}}, m};
          if (op == c6502_pkg::OP_JMP) pc_nxt = ea;

          // multi-step operations
          case (op)
            c6502_pkg::OP_JSR, c6502_pkg::OP_BRK,
            c6502_pkg::OP_PHA, c6502_pkg::OP_PHP: begin
              psh_pc_nxt = pc_r;
              psh_p_nxt  = (op == c6502_pkg::OP_PHA) ? a_r :
                           (op == c6502_pkg::OP_BRK) ? (p_r | 8'h10) : p_r;
              new_pc_nxt = (op == c6502_pkg::OP_JSR) ? ea : irq_vector;
              cnt_nxt    = (op == c6502_pkg::OP_PHA || op == c6502_pkg::OP_PHP)
                           ? 2'd2 : 2'd0;
              state_nxt  = ST_PUSH;
            end
            c6502_pkg::OP_RTS, c6502_pkg::OP_RTI,
            c6502_pkg::OP_PLA, c6502_pkg::OP_PLP: begin
              stk_req.re    = 1'b1;
              stk_req.raddr = s_r + 8'd1;
              s_nxt         = s_r + 8'd1;
              rd_pend_nxt   = 1'b1;
              cnt_nxt       = 2'd0;
              state_nxt     = ST_PULL;
            end
            default: begin
              od_nxt.acc_out = a_nxt; od_nxt.x_out = x_nxt;
              od_nxt.y_out = y_nxt; od_nxt.sp_out = s_nxt;
              od_nxt.status_out = p_nxt; od_nxt.pc_out = pc_nxt;
              ov_nxt = 1'b1;
            end
          endcase
        end
      end

      // one stack byte a cycle; data arrives the cycle after the read
      ST_PULL: begin
        if (rd_pend_r) begin
          cnt_nxt = cnt_r + 2'd1;
          case (cnt_r)
            2'd0: tmp_nxt  = rd_byte;
            2'd1: tmp2_nxt = rd_byte;
            default: ;
          endcase
          if ((op_r == c6502_pkg::OP_PLA || op_r == c6502_pkg::OP_PLP) ||
              (op_r == c6502_pkg::OP_RTS && cnt_r == 2'd1) ||
              (cnt_r == 2'd2)) begin
            case (op_r)
              c6502_pkg::OP_PLA: begin
                a_nxt = rd_byte;
                p_nxt[c6502_pkg::FL_Z] = (rd_byte == 8'h00);
                p_nxt[c6502_pkg::FL_N] = rd_byte[7];
              end
              c6502_pkg::OP_PLP: p_nxt = rd_byte;
              c6502_pkg::OP_RTS: pc_nxt = {rd_byte, tmp_r} + 16'd1;
              default: begin
                p_nxt  = tmp_r;
                pc_nxt = {rd_byte, tmp2_r};
              end
            endcase
            state_nxt = ST_HOLD;
          end else begin
            stk_req.re    = 1'b1;
            stk_req.raddr = s_r + 8'd1;
            s_nxt         = s_r + 8'd1;
            rd_pend_nxt   = 1'b1;
          end
        end
      end

      // one pushed byte per output word
      ST_PUSH: begin
        if (out_free) begin
          od_nxt = '0;
          od_nxt.write_valid   = 1'b1;
          od_nxt.write_address = {c6502_pkg::STACK_PAGE, s_r};
          case (cnt_r)
            2'd0: od_nxt.write_data = psh_pc_r[15:8];
            2'd1: od_nxt.write_data = psh_pc_r[7:0];
            default: od_nxt.write_data = psh_p_r;
          endcase
          stk_req.we    = 1'b1;
          stk_req.waddr = s_r;
          stk_req.wdata = od_nxt.write_data;
          s_nxt   = s_r - 8'd1;
          cnt_nxt = cnt_r + 2'd1;
          if (op_r == c6502_pkg::OP_BRK) begin
            p_nxt[c6502_pkg::FL_B] = 1'b1;
          end
          if (cnt_r == 2'd2 || (op_r == c6502_pkg::OP_JSR && cnt_r == 2'd1)) begin
            od_nxt.last = 1'b1;
            if (op_r == c6502_pkg::OP_BRK) begin
              p_nxt[c6502_pkg::FL_I] = 1'b1;
              pc_nxt = new_pc_r;
            end else if (op_r == c6502_pkg::OP_JSR) begin
              pc_nxt = new_pc_r;
            end
            state_nxt = ST_IDLE;
          end
          // every word reports the registers after the whole operation
          od_nxt.acc_out = a_r; od_nxt.x_out = x_r; od_nxt.y_out = y_r;
          od_nxt.sp_out = (op_r == c6502_pkg::OP_BRK) ? s_r - 8'd3 + {6'd0, cnt_r} :
                          (op_r == c6502_pkg::OP_JSR) ? s_r - 8'd2 + {6'd0, cnt_r} :
                          s_r - 8'd1;
          od_nxt.status_out = (op_r == c6502_pkg::OP_BRK)
                              ? (p_r | 8'h14) : p_r;
          od_nxt.pc_out = (op_r == c6502_pkg::OP_PHA || op_r == c6502_pkg::OP_PHP)
                          ? pc_r : new_pc_r;
          ov_nxt = 1'b1;
        end
      end

      ST_HOLD: begin
        if (out_free) begin
          od_nxt = '0;
          od_nxt.last = 1'b1;
          od_nxt.acc_out = a_r; od_nxt.x_out = x_r; od_nxt.y_out = y_r;
          od_nxt.sp_out = s_r; od_nxt.status_out = p_r; od_nxt.pc_out = pc_r;
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      a_r <= 8'h00; x_r <= 8'h00; y_r <= 8'h00;
      s_r <= c6502_pkg::SP_RESET; p_r <= c6502_pkg::P_RESET;
      pc_r <= c6502_pkg::PC_RESET;
      ov_r <= 1'b0;
      rd_pend_r <= 1'b0;
      fw_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      a_r <= a_nxt; x_r <= x_nxt; y_r <= y_nxt;
      s_r <= s_nxt; p_r <= p_nxt; pc_r <= pc_nxt;
      ov_r <= ov_nxt;
      rd_pend_r <= rd_pend_nxt;
      fw_v_r <= stk_req.we & stk_req.re;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; cnt_r <= cnt_nxt; tmp_r <= tmp_nxt; tmp2_r <= tmp2_nxt;
    psh_pc_r <= psh_pc_nxt; psh_p_r <= psh_p_nxt; new_pc_r <= new_pc_nxt;
    od_r <= od_nxt;
    fw_a_r <= stk_req.waddr; fw_d_r <= stk_req.wdata;
    rd_a_r <= stk_req.raddr;
  end

endmodule

[tb/sv/tb_cpu6502_execute_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cpu6502_execute_core: self-checking bench for the 6502 execute core
// Feeds decoded operations through the input channel, predicts the register
// state and the memory-write words of every operation in a local model, and
// compares each output word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_cpu6502_execute_core;

  localparam logic [5:0] OP_NOP     = 6'd59;
  localparam logic [5:0] OP_SPARE_0 = 6'd60;
  localparam logic [5:0] OP_SPARE_3 = 6'd63;
  localparam int         STALL_LIMIT = 20000;
  localparam int         LONG_HOLD   = 300;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;

  c6502_if #(.word_t(c6502_pkg::in_word_t))  in_ch ();
  c6502_if #(.word_t(c6502_pkg::out_word_t)) out_ch ();

  logic        o_wv, o_last;
  logic [15:0] o_wa, o_pc;
  logic [7:0]  o_wd, o_a, o_x, o_y, o_s, o_p;

  assign out_ch.data = {o_wv, o_wa, o_wd, o_a, o_x, o_y, o_s, o_p, o_pc, o_last};

  cpu6502_execute_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_opcode        (in_ch.data.opcode),
    .in_operand_byte  (in_ch.data.operand_byte),
    .in_addr_low      (in_ch.data.addr_low),
    .in_addr_high     (in_ch.data.addr_high),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_write_valid  (o_wv),
    .out_write_address(o_wa),
    .out_write_data   (o_wd),
    .out_acc_out      (o_a),
    .out_x_out        (o_x),
    .out_y_out        (o_y),
    .out_sp_out       (o_s),
    .out_status_out   (o_p),
    .out_pc_out       (o_pc),
    .out_last         (o_last)
  );

  // 50 MHz clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Model state of the core
  logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_s, cpu_p;
  logic [15:0] cpu_pc;
  logic [7:0]  stack_ram [c6502_pkg::STACK_DEPTH];
  logic [15:0] irq_vec;

  // Writes of the operation being modeled
  int          wr_count;
  logic [15:0] wr_addr [3];
  logic [7:0]  wr_data [3];

  c6502_pkg::out_word_t expected_words [$];
  int        err_cnt;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_left;
  int        quiet_cycles;

  // ---------------------------------------------------------------- model --
  function automatic logic [7:0] set_nz(logic [7:0] v);
    cpu_p[c6502_pkg::FL_Z] = (v == 8'h00);
    cpu_p[c6502_pkg::FL_N] = v[7];
    return v;
  endfunction

  function automatic void mem_write(logic [15:0] addr, logic [7:0] data);
    if (wr_count < 3) begin
      wr_addr[wr_count] = addr;
      wr_data[wr_count] = data;
      wr_count++;
    end
    if (addr[15:8] == c6502_pkg::STACK_PAGE) stack_ram[addr[7:0]] = data;
  endfunction

  function automatic void push_byte(logic [7:0] v);
    mem_write({c6502_pkg::STACK_PAGE, cpu_s}, v);
    cpu_s = cpu_s - 8'd1;
  endfunction

  function automatic logic [7:0] pull_byte();
    cpu_s = cpu_s + 8'd1;
    return stack_ram[cpu_s];
  endfunction

  function automatic void add_with_carry(logic [7:0] m);
    logic [8:0] sum;
    sum = {1'b0, m} + {1'b0, cpu_a} + {8'd0, cpu_p[c6502_pkg::FL_C]};
    cpu_p[c6502_pkg::FL_V] = ((cpu_a ^ sum[7:0]) & (m ^ sum[7:0]) & 8'h80) != 8'h00;
    cpu_p[c6502_pkg::FL_C] = sum[8];
    cpu_a = set_nz(sum[7:0]);
  endfunction

  function automatic void compare_reg(logic [7:0] r, logic [7:0] m);
    logic [7:0] diff;
    diff = r - m;
    cpu_p[c6502_pkg::FL_C] = (r >= m);
    cpu_p[c6502_pkg::FL_Z] = (r == m);
    cpu_p[c6502_pkg::FL_N] = diff[7];
  endfunction

  // kind: 0 ASL, 1 LSR, 2 ROL, 3 ROR
  function automatic logic [7:0] shift_byte(int kind, logic [7:0] v);
    logic cin;
    logic [7:0] r;
    cin = cpu_p[c6502_pkg::FL_C];
    if (kind == 0 || kind == 2) begin
      cpu_p[c6502_pkg::FL_C] = v[7];
      r = {v[6:0], (kind == 2) ? cin : 1'b0};
    end else begin
      cpu_p[c6502_pkg::FL_C] = v[0];
      r = {(kind == 3) ? cin : 1'b0, v[7:1]};
    end
    return set_nz(r);
  endfunction

  // Apply one operation to the model and queue the words it produces
  task automatic execute_word(c6502_pkg::in_word_t w);
    logic [7:0]  m, p0, lo, hi;
    logic [15:0] ea;
    logic        take;
    int          n;
    c6502_pkg::out_word_t r;
    m = w.operand_byte;
    ea = {w.addr_high, w.addr_low};
    p0 = cpu_p;
    take = 1'b0;
    wr_count = 0;
    case (w.opcode)
      c6502_pkg::OP_LDA: cpu_a = set_nz(m);
      c6502_pkg::OP_LDX: cpu_x = set_nz(m);
      c6502_pkg::OP_LDY: cpu_y = set_nz(m);
      c6502_pkg::OP_STA: mem_write(ea, cpu_a);
      c6502_pkg::OP_STX: mem_write(ea, cpu_x);
      c6502_pkg::OP_STY: mem_write(ea, cpu_y);
      c6502_pkg::OP_TAX: cpu_x = set_nz(cpu_a);
      c6502_pkg::OP_TAY: cpu_y = set_nz(cpu_a);
      c6502_pkg::OP_TSX: cpu_x = set_nz(cpu_s);
      c6502_pkg::OP_TXA: cpu_a = set_nz(cpu_x);
      c6502_pkg::OP_TXS: cpu_s = cpu_x;
      c6502_pkg::OP_TYA: cpu_a = set_nz(cpu_y);
      c6502_pkg::OP_INC: mem_write(ea, set_nz(m + 8'd1));
      c6502_pkg::OP_INX: cpu_x = set_nz(cpu_x + 8'd1);
      c6502_pkg::OP_INY: cpu_y = set_nz(cpu_y + 8'd1);
      c6502_pkg::OP_DEC: mem_write(ea, set_nz(m - 8'd1));
      c6502_pkg::OP_DEX: cpu_x = set_nz(cpu_x - 8'd1);
      c6502_pkg::OP_DEY: cpu_y = set_nz(cpu_y - 8'd1);
      c6502_pkg::OP_ASLM, c6502_pkg::OP_LSRM, c6502_pkg::OP_ROLM, c6502_pkg::OP_RORM:
        mem_write(ea, shift_byte(int'(w.opcode - c6502_pkg::OP_ASLM), m));
      c6502_pkg::OP_ASLA, c6502_pkg::OP_LSRA, c6502_pkg::OP_ROLA, c6502_pkg::OP_RORA:
        cpu_a = shift_byte(int'(w.opcode - c6502_pkg::OP_ASLA), cpu_a);
      c6502_pkg::OP_AND: cpu_a = set_nz(cpu_a & m);
      c6502_pkg::OP_EOR: cpu_a = set_nz(cpu_a ^ m);
      c6502_pkg::OP_ORA: cpu_a = set_nz(cpu_a | m);
      c6502_pkg::OP_BIT: begin
        cpu_p[c6502_pkg::FL_Z] = ((cpu_a & m) == 8'h00);
        cpu_p[c6502_pkg::FL_N] = m[7];
        cpu_p[c6502_pkg::FL_V] = m[6];
      end
      c6502_pkg::OP_ADC: add_with_carry(m);
      c6502_pkg::OP_SBC: add_with_carry(~m);
      c6502_pkg::OP_CMP: compare_reg(cpu_a, m);
      c6502_pkg::OP_CPX: compare_reg(cpu_x, m);
      c6502_pkg::OP_CPY: compare_reg(cpu_y, m);
      c6502_pkg::OP_CLC: cpu_p[c6502_pkg::FL_C] = 1'b0;
      c6502_pkg::OP_CLD: cpu_p[c6502_pkg::FL_D] = 1'b0;
      c6502_pkg::OP_CLI: cpu_p[c6502_pkg::FL_I] = 1'b0;
      c6502_pkg::OP_CLV: cpu_p[c6502_pkg::FL_V] = 1'b0;
      c6502_pkg::OP_SEC: cpu_p[c6502_pkg::FL_C] = 1'b1;
      c6502_pkg::OP_SED: cpu_p[c6502_pkg::FL_D] = 1'b1;
      c6502_pkg::OP_SEI: cpu_p[c6502_pkg::FL_I] = 1'b1;
      c6502_pkg::OP_BCC: take = !p0[c6502_pkg::FL_C];
      c6502_pkg::OP_BCS: take = p0[c6502_pkg::FL_C];
      c6502_pkg::OP_BEQ: take = p0[c6502_pkg::FL_Z];
      c6502_pkg::OP_BMI: take = p0[c6502_pkg::FL_N];
      c6502_pkg::OP_BNE: take = !p0[c6502_pkg::FL_Z];
      c6502_pkg::OP_BPL: take = !p0[c6502_pkg::FL_N];
      c6502_pkg::OP_BVC: take = !p0[c6502_pkg::FL_V];
      c6502_pkg::OP_BVS: take = p0[c6502_pkg::FL_V];
      c6502_pkg::OP_JMP: cpu_pc = ea;
      c6502_pkg::OP_JSR: begin
        push_byte(cpu_pc[15:8]);
        push_byte(cpu_pc[7:0]);
        cpu_pc = ea;
      end
      c6502_pkg::OP_RTS: begin
        lo = pull_byte();
        hi = pull_byte();
        cpu_pc = {hi, lo} + 16'd1;
      end
      c6502_pkg::OP_RTI: begin
        cpu_p = pull_byte();
        lo = pull_byte();
        hi = pull_byte();
        cpu_pc = {hi, lo};
      end
      c6502_pkg::OP_BRK: begin
        cpu_p[c6502_pkg::FL_B] = 1'b1;
        push_byte(cpu_pc[15:8]);
        push_byte(cpu_pc[7:0]);
        push_byte(cpu_p);
        cpu_p[c6502_pkg::FL_I] = 1'b1;
        cpu_pc = irq_vec;
      end
      c6502_pkg::OP_PHA: push_byte(cpu_a);
      c6502_pkg::OP_PHP: push_byte(cpu_p);
      c6502_pkg::OP_PLA: cpu_a = set_nz(pull_byte());
      c6502_pkg::OP_PLP: cpu_p = pull_byte();
      default: ;
    endcase
    // displacement is signed
    if (take) cpu_pc = cpu_pc + {{8{m[7]}}, m};

    n = (wr_count > 0) ? wr_count : 1;
    for (int k = 0; k < n; k++) begin
      r.write_valid   = (k < wr_count);
      r.write_address = (k < wr_count) ? wr_addr[k] : 16'h0000;
      r.write_data    = (k < wr_count) ? wr_data[k] : 8'h00;
      r.acc_out       = cpu_a;
      r.x_out         = cpu_x;
      r.y_out         = cpu_y;
      r.sp_out        = cpu_s;
      r.status_out    = cpu_p;
      r.pc_out        = cpu_pc;
      r.last          = (k == n - 1);
      expected_words.push_back(r);
    end
  endtask

  // ------------------------------------------------------------- checking --
  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_word(c6502_pkg::out_word_t got);
    c6502_pkg::out_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("output word with nothing expected");
      return;
    end
    want = expected_words.pop_front();
    if (got.write_valid !== want.write_valid)
      report_mismatch($sformatf("write_valid %0b want %0b", got.write_valid, want.write_valid));
    if (got.write_address !== want.write_address)
      report_mismatch($sformatf("write_address %h want %h", got.write_address,
                                want.write_address));
    if (got.write_data !== want.write_data)
      report_mismatch($sformatf("write_data %h want %h", got.write_data, want.write_data));
    if (got.acc_out !== want.acc_out)
      report_mismatch($sformatf("acc_out %h want %h", got.acc_out, want.acc_out));
    if (got.x_out !== want.x_out)
      report_mismatch($sformatf("x_out %h want %h", got.x_out, want.x_out));
    if (got.y_out !== want.y_out)
      report_mismatch($sformatf("y_out %h want %h", got.y_out, want.y_out));
    if (got.sp_out !== want.sp_out)
      report_mismatch($sformatf("sp_out %h want %h", got.sp_out, want.sp_out));
    if (got.status_out !== want.status_out)
      report_mismatch($sformatf("status_out %h want %h", got.status_out, want.status_out));
    if (got.pc_out !== want.pc_out)
      report_mismatch($sformatf("pc_out %h want %h", got.pc_out, want.pc_out));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %0b want %0b", got.last, want.last));
  endtask

  // Result side: random stalls, long hold-off on request, check on handshake
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_word(out_ch.data);
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------- stimulus --
  task automatic send_word(c6502_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    execute_word(w);
  endtask

  task automatic send_op(logic [5:0] op, logic [7:0] m, logic [15:0] ea);
    c6502_pkg::in_word_t w;
    w.opcode = op;
    w.operand_byte = m;
    w.addr_low = ea[7:0];
    w.addr_high = ea[15:8];
    send_word(w);
  endtask

  function automatic c6502_pkg::in_word_t random_word();
    c6502_pkg::in_word_t w;
    w.opcode       = 6'($urandom_range(63));
    w.operand_byte = 8'($urandom);
    w.addr_low     = 8'($urandom);
    w.addr_high    = ($urandom_range(3) == 0) ? c6502_pkg::STACK_PAGE : 8'($urandom);
    return w;
  endfunction

  // Let every expected word arrive, then the pipeline settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_irq_vector(logic [15:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    irq_vec = v;
  endtask

  task automatic test_directed();
    send_op(c6502_pkg::OP_LDA, 8'h00, 16'h0000);
    send_op(c6502_pkg::OP_LDA, 8'hFF, 16'hFFFF);
    send_op(c6502_pkg::OP_LDX, 8'h80, 16'h0000);
    send_op(c6502_pkg::OP_LDY, 8'h7F, 16'h0000);
    send_op(c6502_pkg::OP_SED, 8'h00, 16'h0000);
    send_op(c6502_pkg::OP_LDA, 8'h7F, 16'h0000);
    send_op(c6502_pkg::OP_ADC, 8'h01, 16'h0000);      // signed overflow, decimal ignored
    send_op(c6502_pkg::OP_SBC, 8'hFF, 16'h0000);
    send_op(c6502_pkg::OP_BMI, 8'h80, 16'h0000);      // backward branch
    send_op(c6502_pkg::OP_BVS, 8'h7F, 16'h0000);
    send_op(c6502_pkg::OP_STA, 8'h00, 16'h01FF);      // store into the stack page
    send_op(c6502_pkg::OP_PLA, 8'h00, 16'h0000);      // S wraps FF -> 00
    send_op(c6502_pkg::OP_LDX, 8'h00, 16'h0000);
    send_op(c6502_pkg::OP_TXS, 8'h00, 16'h0000);
    send_op(c6502_pkg::OP_PHA, 8'h00, 16'h0000);      // S wraps 00 -> FF
    send_op(c6502_pkg::OP_INC, 8'hFF, 16'h0180);      // read-modify-write on page one
    send_op(c6502_pkg::OP_JSR, 8'h00, 16'h1234);
    send_op(c6502_pkg::OP_RTS, 8'h00, 16'h0000);
    send_op(c6502_pkg::OP_BRK, 8'h00, 16'h0000);
    send_op(c6502_pkg::OP_RTI, 8'h00, 16'h0000);
    send_op(c6502_pkg::OP_PHP, 8'h00, 16'h0000);
    send_op(c6502_pkg::OP_PLP, 8'h00, 16'h0000);
    send_op(OP_NOP, 8'hAA, 16'h5555);
    send_op(OP_SPARE_0, 8'h55, 16'hAAAA);
    send_op(OP_SPARE_3, 8'hFF, 16'hFFFF);
  endtask

  // Every opcode once with random operands
  task automatic test_opcode_sweep();
    c6502_pkg::in_word_t w;
    for (int op = 0; op < 64; op++) begin
      w = random_word();
      w.opcode = 6'(op);
      send_word(w);
    end
  endtask

  // Subroutine and interrupt frames with random bodies, push/pull pairs, mostly single random words
  task automatic test_random(int count);
    int sent;
    int pick;
    int body;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      body = $urandom_range(2);
      if (pick < 20) begin
        send_op(c6502_pkg::OP_JSR, 8'($urandom), 16'($urandom));
        repeat (body) send_word(random_word());
        send_op(c6502_pkg::OP_RTS, 8'($urandom), 16'($urandom));
        sent += 2 + body;
      end else if (pick < 35) begin
        send_op(c6502_pkg::OP_BRK, 8'($urandom), 16'($urandom));
        repeat (body) send_word(random_word());
        send_op(c6502_pkg::OP_RTI, 8'($urandom), 16'($urandom));
        sent += 2 + body;
      end else if (pick < 45) begin
        send_op(c6502_pkg::OP_LDA, 8'($urandom), 16'($urandom));
        send_op(c6502_pkg::OP_PHA, 8'($urandom), 16'($urandom));
        send_op(c6502_pkg::OP_PLA, 8'($urandom), 16'($urandom));
        sent += 3;
      end else begin
        send_word(random_word());
        sent++;
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    hold_left = LONG_HOLD;
    repeat (20) send_word(random_word());
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 16'h0000;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    err_cnt = 0;
    hold_left = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cpu_a = 8'h00;
    cpu_x = 8'h00;
    cpu_y = 8'h00;
    cpu_s = c6502_pkg::SP_RESET;
    cpu_p = c6502_pkg::P_RESET;
    cpu_pc = c6502_pkg::PC_RESET;
    irq_vec = 16'h0000;
    for (int i = 0; i < c6502_pkg::STACK_DEPTH; i++) stack_ram[i] = 8'h00;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    write_irq_vector(16'hFFFF);
    test_opcode_sweep();

    write_irq_vector(16'h0000);
    send_idle_pct = 81;
    test_random(33);

    write_irq_vector(16'($urandom));
    send_idle_pct = 0;
    recv_stall_pct = 81;
    test_random(33);

    write_irq_vector(16'h8000);
    send_idle_pct = 15;
    recv_stall_pct = 15;
    test_random(33);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();

    drain();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
